[rtl/alpe_pkg.sv]
// Shared types and constants for the addressable LED line encoder.
// Holds register indexes, input kind codes, reset values and the command struct.
// No dependencies.
package alpe_pkg;

    localparam int DEF_MAX_PIXELS = 32;
    localparam int BITS_PER_PIXEL = 24;

    localparam int PIX_W   = 24;
    localparam int TICK_W  = 16;
    localparam int RSLOT_W = 10;
    localparam int CNT_IN_W = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RST_SLOTS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIX_COUNT = 3'd4;

    // Input word kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_SHOW  = 2'd2;

    localparam logic [TICK_W-1:0]  RST_PERIOD    = 16'd135;
    localparam logic [TICK_W-1:0]  RST_ONE_HIGH  = 16'd86;
    localparam logic [TICK_W-1:0]  RST_ZERO_HIGH = 16'd43;
    localparam logic [RSLOT_W-1:0] RST_RST_SLOTS = 10'd50;

    // Accepted word decoded for the slot timer and the pixel memory
    typedef struct packed {
        logic tick;
        logic show;
    } frame_cmd_t;

endpackage

[rtl/addressable_led_pwm_encoder.sv]
// Top level of the addressable LED line encoder: handshakes, registers,
// output register. Instantiates alpe_pixel_mem and alpe_slot_timer.
// Depends on alpe_pkg.
//
//  channel  | ports                               | direction
//  ---------+-------------------------------------+----------
//  input    | s_valid s_ready s_kind s_pixel_index | in
//           | s_red s_green s_blue                 |
//  result   | m_valid m_ready m_line_level         | out
//           | m_busy_res m_show_taken              |
//  config   | cfg_wr_en cfg_index cfg_wdata        | in
//
// One word is taken every cycle while s_ready is high; each gives one registered result word.
// The pixel memory is read one pixel ahead of the slot timer, so a tick may
// follow a show or a pixel write in the next cycle.
// s_ready drops only while the output register holds a word not taken.
// Synchronous active-low reset; memory contents need no clearing pass.
module addressable_led_pwm_encoder #(
    parameter int MAX_PIXELS = alpe_pkg::DEF_MAX_PIXELS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_kind,
    input  logic [4:0]                     s_pixel_index,
    input  logic [7:0]                     s_red,
    input  logic [7:0]                     s_green,
    input  logic [7:0]                     s_blue,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_line_level,
    output logic                           m_busy_res,
    output logic                           m_show_taken,
    input  logic                           cfg_wr_en,
    input  logic [alpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [alpe_pkg::CFG_DAT_W-1:0] cfg_wdata
);
    import alpe_pkg::*;

    localparam int IW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int PW = $clog2(MAX_PIXELS + 1);

    logic [TICK_W-1:0]  period_reg;
    logic [TICK_W-1:0]  one_high_reg;
    logic [TICK_W-1:0]  zero_high_reg;
    logic [RSLOT_W-1:0] rst_slots_reg;
    logic [PW-1:0]      pix_count_reg;
    logic [PW-1:0]      pix_count_next;

    logic       out_valid_reg;
    logic       line_reg, busy_reg, taken_reg;

    logic       accept;
    logic       sending, sending_next, line;
    logic       wr_en, clr_en, show_go;
    logic [IW-1:0]    wr_idx, rd_idx;
    logic [PIX_W-1:0] wr_grb, rd_pix;
    logic [10:0]      cnt_in;
    frame_cmd_t       cmd;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign show_go = accept && (s_kind == KIND_SHOW) && !sending;

    assign cmd.tick = accept && (s_kind == KIND_TICK);
    assign cmd.show = show_go;

    // Drop writes at or above the pixel count
    assign wr_en  = accept && (s_kind == KIND_WRITE) &&
                    (11'(s_pixel_index) < 11'(pix_count_reg));
    assign wr_idx = IW'(s_pixel_index);
    assign wr_grb = {s_green, s_red, s_blue};

    // Saturate the pixel count at the store depth
    assign cnt_in = 11'(cfg_wdata[CNT_IN_W-1:0]);
    assign pix_count_next = (cnt_in > 11'(MAX_PIXELS)) ? PW'(MAX_PIXELS) : PW'(cnt_in);
    assign clr_en = cfg_wr_en && (cfg_index == REG_PIX_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= RST_PERIOD;
            one_high_reg  <= RST_ONE_HIGH;
            zero_high_reg <= RST_ZERO_HIGH;
            rst_slots_reg <= RST_RST_SLOTS;
            pix_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PERIOD: begin
                    period_reg <= cfg_wdata;
                end
                REG_ONE_HIGH: begin
                    one_high_reg <= cfg_wdata;
                end
                REG_ZERO_HIGH: begin
                    zero_high_reg <= cfg_wdata;
                end
                REG_RST_SLOTS: begin
                    rst_slots_reg <= cfg_wdata[RSLOT_W-1:0];
                end
                REG_PIX_COUNT: begin
                    pix_count_reg <= pix_count_next;
                end
                default: begin
                end
            endcase
        end
    end

    alpe_pixel_mem #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_grb  (wr_grb),
        .clr_en  (clr_en),
        .clr_cnt (pix_count_next),
        .rd_idx  (rd_idx),
        .rd_pix  (rd_pix)
    );

    alpe_slot_timer #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_timer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .period_ticks    (period_reg),
        .one_high_ticks  (one_high_reg),
        .zero_high_ticks (zero_high_reg),
        .reset_slots     (rst_slots_reg),
        .pixel_count     (pix_count_reg),
        .rd_pix          (rd_pix),
        .rd_idx          (rd_idx),
        .sending         (sending),
        .sending_next    (sending_next),
        .line            (line)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            line_reg  <= cmd.tick && line;
            busy_reg  <= sending_next;
            taken_reg <= show_go;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_line_level = line_reg;
    assign m_busy_res   = busy_reg;
    assign m_show_taken = taken_reg;

`ifndef ASSERT_OFF
    a_taken_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        show_go |=> (sending == $past(sending_next)))
        else $error("busy flag did not follow a taken show");
    a_show_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_kind == KIND_SHOW && sending) |=> !taken_reg)
        else $error("show reported taken while busy");
    a_line_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd.tick && line) |-> sending)
        else $error("line driven high while idle");
`endif

endmodule

[rtl/alpe_pixel_mem.sv]
// Two-bank pixel memory with per-entry bank select and zero flags.
// A show snapshots the bank selects; later writes go to the other bank.
// Depends on alpe_pkg.
module alpe_pixel_mem #(
    parameter int MAX_PIXELS = alpe_pkg::DEF_MAX_PIXELS,
    localparam int IW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
    localparam int PW = $clog2(MAX_PIXELS + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  alpe_pkg::frame_cmd_t       cmd,
    input  logic                       wr_en,
    input  logic [IW-1:0]              wr_idx,
    input  logic [alpe_pkg::PIX_W-1:0] wr_grb,
    input  logic                       clr_en,
    input  logic [PW-1:0]              clr_cnt,
    input  logic [IW-1:0]              rd_idx,
    output logic [alpe_pkg::PIX_W-1:0] rd_pix
);
    import alpe_pkg::*;

    localparam int AW = IW + 1;
    localparam int DEPTH = 2 * (1 << IW);

    logic [PIX_W-1:0] mem [DEPTH];

    logic [MAX_PIXELS-1:0] live_sel_reg, live_sel_next;
    logic [MAX_PIXELS-1:0] frame_sel_reg, frame_sel_next;
    logic [MAX_PIXELS-1:0] live_zero_reg, live_zero_next;
    logic [MAX_PIXELS-1:0] frame_zero_reg, frame_zero_next;

    logic [PIX_W-1:0] rd_data_reg;
    logic             rd_zero_reg;
    logic [AW-1:0]    rd_addr;
    logic             rd_zero;
    logic [AW-1:0]    wr_addr;

    assign wr_addr = {~frame_sel_reg[wr_idx], wr_idx};

    // On a show the frame selects are not yet loaded: read entry 0 by its live bank
    always_comb begin
        if (cmd.show) begin
            rd_addr = {live_sel_reg[0], {IW{1'b0}}};
            rd_zero = live_zero_reg[0];
        end else begin
            rd_addr = {frame_sel_reg[rd_idx], rd_idx};
            rd_zero = frame_zero_reg[rd_idx];
        end
    end

    always_comb begin
        live_sel_next   = live_sel_reg;
        frame_sel_next  = frame_sel_reg;
        live_zero_next  = live_zero_reg;
        frame_zero_next = frame_zero_reg;
        if (wr_en) begin
            live_sel_next[wr_idx]  = ~frame_sel_reg[wr_idx];
            live_zero_next[wr_idx] = 1'b0;
        end
        if (cmd.show) begin
            frame_sel_next  = live_sel_reg;
            frame_zero_next = live_zero_reg;
        end
        if (clr_en) begin
            for (int i = 0; i < MAX_PIXELS; i++) begin
                if (PW'(i) < clr_cnt) begin
                    live_zero_next[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_sel_reg   <= '0;
            frame_sel_reg  <= '0;
            live_zero_reg  <= '1;
            frame_zero_reg <= '1;
        end else begin
            live_sel_reg   <= live_sel_next;
            frame_sel_reg  <= frame_sel_next;
            live_zero_reg  <= live_zero_next;
            frame_zero_reg <= frame_zero_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_grb;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        rd_zero_reg <= rd_zero;
    end

    assign rd_pix = rd_zero_reg ? '0 : rd_data_reg;

`ifndef ASSERT_OFF
    // A write never lands in the bank that the current frame reads
    a_wr_off_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> live_sel_reg[$past(wr_idx)] != frame_sel_reg[$past(wr_idx)])
        else $error("pixel write hit the frame bank");
    // A show and a write never arrive together
    a_show_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && cmd.show))
        else $error("write and show in the same cycle");
    // After a show the frame snapshot matches what was live
    a_snapshot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.show |=> frame_sel_reg == $past(live_sel_reg))
        else $error("frame bank select snapshot lost");
`endif

endmodule

[rtl/alpe_slot_timer.sv]
// Slot and tick counters that shape the line waveform for one frame.
// Holds the current pixel word, fed from the pixel memory one pixel ahead.
// Depends on alpe_pkg.
module alpe_slot_timer #(
    parameter int MAX_PIXELS = alpe_pkg::DEF_MAX_PIXELS,
    localparam int IW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
    localparam int PW = $clog2(MAX_PIXELS + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  alpe_pkg::frame_cmd_t         cmd,
    input  logic [alpe_pkg::TICK_W-1:0]  period_ticks,
    input  logic [alpe_pkg::TICK_W-1:0]  one_high_ticks,
    input  logic [alpe_pkg::TICK_W-1:0]  zero_high_ticks,
    input  logic [alpe_pkg::RSLOT_W-1:0] reset_slots,
    input  logic [PW-1:0]                pixel_count,
    input  logic [alpe_pkg::PIX_W-1:0]   rd_pix,
    output logic [IW-1:0]                rd_idx,
    output logic                         sending,
    output logic                         sending_next,
    output logic                         line
);
    import alpe_pkg::*;

    localparam logic [4:0] LAST_BIT = 5'(BITS_PER_PIXEL - 1);

    logic               sending_reg;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [4:0]         bit_reg, bit_next;
    logic [PW-1:0]      px_reg, px_next;
    logic [RSLOT_W-1:0] rs_reg, rs_next;
    logic [PW-1:0]      fpix_reg, fpix_next;
    logic [RSLOT_W-1:0] frs_reg, frs_next;
    logic [PIX_W-1:0]   cur_reg, cur_next;
    logic               pend_reg, pend_next;

    logic [PIX_W-1:0]   cur_pix;
    logic [TICK_W-1:0]  high_ticks;
    logic               in_data;
    logic               slot_end;
    logic               last_bit;

    assign cur_pix    = pend_reg ? rd_pix : cur_reg;
    assign in_data    = px_reg < fpix_reg;
    assign high_ticks = cur_pix[LAST_BIT - bit_reg] ? one_high_ticks : zero_high_ticks;
    assign line       = sending_reg && in_data && (tick_reg < high_ticks);
    assign slot_end   = ({1'b0, tick_reg} + 17'd1) >= {1'b0, period_ticks};
    assign last_bit   = bit_reg == LAST_BIT;
    assign rd_idx     = px_reg[IW-1:0] + IW'(1);
    assign sending    = sending_reg;

    always_comb begin
        sending_next = sending_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        px_next      = px_reg;
        rs_next      = rs_reg;
        fpix_next    = fpix_reg;
        frs_next     = frs_reg;
        cur_next     = cur_reg;
        pend_next    = 1'b0;
        if (pend_reg) begin
            cur_next = rd_pix;
        end
        if (cmd.show) begin
            tick_next    = '0;
            bit_next     = '0;
            px_next      = '0;
            rs_next      = '0;
            fpix_next    = pixel_count;
            frs_next     = reset_slots;
            pend_next    = 1'b1;
            sending_next = (pixel_count != '0) || (reset_slots != '0);
        end else if (cmd.tick && sending_reg) begin
            if (slot_end) begin
                tick_next = '0;
                if (in_data) begin
                    if (last_bit) begin
                        // advance to the next pixel, already read ahead
                        bit_next = '0;
                        px_next  = px_reg + PW'(1);
                        cur_next = rd_pix;
                        if ((px_reg + PW'(1)) == fpix_reg && frs_reg == '0) begin
                            sending_next = 1'b0;
                        end
                    end else begin
                        bit_next = bit_reg + 5'd1;
                    end
                end else begin
                    rs_next = rs_reg + RSLOT_W'(1);
                    if (({1'b0, rs_reg} + 11'd1) == {1'b0, frs_reg}) begin
                        sending_next = 1'b0;
                    end
                end
            end else begin
                tick_next = tick_reg + TICK_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg <= 1'b0;
            tick_reg    <= '0;
            bit_reg     <= '0;
            px_reg      <= '0;
            rs_reg      <= '0;
            fpix_reg    <= '0;
            frs_reg     <= '0;
            pend_reg    <= 1'b0;
        end else begin
            sending_reg <= sending_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            px_reg      <= px_next;
            rs_reg      <= rs_next;
            fpix_reg    <= fpix_next;
            frs_reg     <= frs_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

`ifndef ASSERT_OFF
    a_idle_tick_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !sending_reg |-> tick_reg == '0)
        else $error("tick counter left running while idle");
    a_px_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        px_reg <= fpix_reg)
        else $error("pixel counter ran past the frame");
    a_rs_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (sending_reg && !in_data) |-> rs_reg < frs_reg)
        else $error("reset slot counter ran past its end");
    a_bit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_reg <= LAST_BIT)
        else $error("bit counter out of range");
    a_pend_after_show: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> $past(cmd.show))
        else $error("pixel load pending without a show");
`endif

endmodule
